>>> sv/tsle_pkg.sv
// shared types and constants for the ustar line extractor
// used by tsle_hdr, tar_stream_line_extractor_core and tsle_chk
`default_nettype none

package tsle_pkg;

	localparam int SIZE_WIDTH_DEF = 64;

	localparam int BLOCK_BYTES = 512;
	localparam int POS_W       = $clog2(BLOCK_BYTES);

	localparam logic [POS_W-1:0] POS_SIZE_FIRST  = POS_W'(124);
	localparam logic [POS_W-1:0] POS_SIZE_BIN0   = POS_W'(125);
	localparam logic [POS_W-1:0] POS_SIZE_DIGEND = POS_W'(134);
	localparam logic [POS_W-1:0] POS_SIZE_LAST   = POS_W'(135);
	localparam logic [POS_W-1:0] POS_MAGIC_FIRST = POS_W'(257);
	localparam logic [POS_W-1:0] POS_MAGIC_LAST  = POS_W'(261);
	localparam logic [POS_W-1:0] POS_HDR_LAST    = POS_W'(BLOCK_BYTES - 1);

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_BAD_TERM  = 3'd2;
	localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
	localparam logic [2:0] ST_NO_LF     = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CONTENT,
		PH_PAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic pos_zero;
		logic last;
		logic blank;
		logic magic_bad;
		logic term_bad;
		logic digit_bad;
		logic binary;
	} hdr_stat_t;

	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h75;
			3'd1: c = 8'h73;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h72;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/tsle_hdr.sv
// ustar header parser: position counter, magic and size field checks
// depends on tsle_pkg
`default_nettype none

module tsle_hdr
	import tsle_pkg::*;
#(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic [7:0]            data_byte,
	output hdr_stat_t                  stat,
	output logic      [SIZE_WIDTH-1:0] size
);

	logic [POS_W-1:0]      pos_q;
	logic [SIZE_WIDTH-1:0] acc_q, acc_d;
	logic                  bin_q, bin_d;
	logic                  az_q, az_d;
	logic                  mb_q, mb_d;
	logic                  tb_q, tb_d;
	logic                  db_q, db_d;
	logic [POS_W-1:0]      midx;
	logic                  last;

	assign midx = pos_q - POS_MAGIC_FIRST;
	assign last = (pos_q == POS_HDR_LAST);

	always_comb begin
		az_d  = az_q && (data_byte == CH_NUL);
		mb_d  = mb_q;
		bin_d = bin_q;
		acc_d = acc_q;
		tb_d  = tb_q;
		db_d  = db_q;
		if (pos_q >= POS_MAGIC_FIRST && pos_q <= POS_MAGIC_LAST &&
				data_byte != magic_char(midx[2:0])) begin
			mb_d = 1'b1;
		end
		if (pos_q == POS_SIZE_FIRST) begin
			bin_d = data_byte[7];
		end
		if (pos_q >= POS_SIZE_FIRST && pos_q <= POS_SIZE_LAST) begin
			if (bin_d) begin
				if (pos_q >= POS_SIZE_BIN0) begin
					acc_d = {acc_q[SIZE_WIDTH-9:0], data_byte};
				end
			end else if (pos_q <= POS_SIZE_DIGEND) begin
				if (data_byte inside {[CH_ZERO:CH_SEVEN]}) begin
					acc_d = {acc_q[SIZE_WIDTH-4:0], data_byte[2:0]};
				end else begin
					db_d = 1'b1;
				end
			end else if (data_byte != CH_SPACE && data_byte != CH_NUL) begin
				tb_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
			bin_q <= 1'b0;
			az_q  <= 1'b1;
			mb_q  <= 1'b0;
			tb_q  <= 1'b0;
			db_q  <= 1'b0;
		end else if (en) begin
			if (last) begin
				pos_q <= '0;
				acc_q <= '0;
				bin_q <= 1'b0;
				az_q  <= 1'b1;
				mb_q  <= 1'b0;
				tb_q  <= 1'b0;
				db_q  <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				acc_q <= acc_d;
				bin_q <= bin_d;
				az_q  <= az_d;
				mb_q  <= mb_d;
				tb_q  <= tb_d;
				db_q  <= db_d;
			end
		end
	end

	assign stat.pos_zero  = (pos_q == '0);
	assign stat.last      = last;
	assign stat.blank     = az_d;
	assign stat.magic_bad = mb_d;
	assign stat.term_bad  = tb_d;
	assign stat.digit_bad = db_d;
	assign stat.binary    = bin_d;
	assign size           = acc_d;

endmodule

`default_nettype wire

>>> sv/tar_stream_line_extractor_core.sv
// a byte is held in the input register, and its result is registered in the result register as it advances
// throughput: one byte per cycle (input and result registers) unless m_axis_tready stalls
// zero-length entries, pad bytes and the bytes of a valid header produce no result
// reset: arst_n asynchronous, clears phase, counters, header flags and both valid bits
// depends on tsle_pkg and tsle_hdr
`default_nettype none

module tar_stream_line_extractor_core
	import tsle_pkg::*;
#(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // data_byte
	input  wire logic       s_axis_tuser,   // kind
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // byte_out
	output logic [7:0]      m_axis_tuser    // byte_valid, line_end, archive_end, status[2:0], 0, 0
);

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] data_s1;
	logic       advance;

	phase_t                phase_q, phase_d;
	logic [SIZE_WIDTH-1:0] content_q, content_d;
	logic [POS_W-1:0]      pad_q, pad_d;

	hdr_stat_t             hstat;
	logic [SIZE_WIDTH-1:0] hsize;
	logic                  hdr_en;

	logic       emit;
	logic [7:0] r_byte;
	logic       r_bv, r_le, r_ae;
	logic [2:0] r_st;

	logic       out_valid_q;
	logic [7:0] obyte_q;
	logic       obv_q, ole_q, oae_q;
	logic [2:0] ost_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign hdr_en        = advance && (kind_s1 == KIND_DATA) && (phase_q == PH_HEADER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			data_s1 <= s_axis_tdata;
		end
	end

	tsle_hdr #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_hdr (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (hdr_en),
		.data_byte(data_s1),
		.stat     (hstat),
		.size     (hsize)
	);

	always_comb begin
		phase_d   = phase_q;
		content_d = content_q;
		pad_d     = pad_q;
		emit      = 1'b0;
		r_byte    = 8'h00;
		r_bv      = 1'b0;
		r_le      = 1'b0;
		r_ae      = 1'b0;
		r_st      = ST_OK;
		if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
			emit = 1'b0;
		end else if (kind_s1 == KIND_EOS) begin
			emit = 1'b1;
			if (phase_q == PH_HEADER && hstat.pos_zero) begin
				phase_d = PH_DONE;
				r_ae    = 1'b1;
			end else begin
				phase_d = PH_ERROR;
				r_st    = ST_TRUNC;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (hstat.last) begin
						if (hstat.blank) begin
							phase_d = PH_DONE;
							emit    = 1'b1;
							r_ae    = 1'b1;
						end else if (hstat.magic_bad) begin
							phase_d = PH_ERROR;
							emit    = 1'b1;
							r_st    = ST_BAD_MAGIC;
						end else if (!hstat.binary && hstat.term_bad) begin
							phase_d = PH_ERROR;
							emit    = 1'b1;
							r_st    = ST_BAD_TERM;
						end else if (!hstat.binary && hstat.digit_bad) begin
							phase_d = PH_ERROR;
							emit    = 1'b1;
							r_st    = ST_BAD_DIGIT;
						end else begin
							content_d = hsize;
							pad_d     = POS_W'(0) - hsize[POS_W-1:0];
							if (|hsize) begin
								phase_d = PH_CONTENT;
							end else if (|pad_d) begin
								phase_d = PH_PAD;
							end else begin
								phase_d = PH_HEADER;
							end
						end
					end
				end
				PH_CONTENT: begin
					content_d = content_q - SIZE_WIDTH'(1);
					if (content_q == SIZE_WIDTH'(1)) begin
						emit = 1'b1;
						if (data_s1 != CH_LF) begin
							phase_d = PH_ERROR;
							r_st    = ST_NO_LF;
						end else begin
							phase_d = (|pad_q) ? PH_PAD : PH_HEADER;
							r_le    = 1'b1;
						end
					end else if (data_s1 == CH_LF) begin
						emit = 1'b1;
						r_le = 1'b1;
					end else if (data_s1 != CH_CR) begin
						emit   = 1'b1;
						r_bv   = 1'b1;
						r_byte = data_s1;
					end
				end
				PH_PAD: begin
					pad_d = pad_q - POS_W'(1);
					if (pad_d == '0) begin
						phase_d = PH_HEADER;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			content_q <= '0;
			pad_q     <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			content_q <= content_d;
			pad_q     <= pad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			obyte_q <= r_byte;
			obv_q   <= r_bv;
			ole_q   <= r_le;
			oae_q   <= r_ae;
			ost_q   <= r_st;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = obyte_q;
	assign m_axis_tuser  = {2'b00, ost_q, oae_q, ole_q, obv_q};

endmodule

`default_nettype wire

>>> sv/tsle_chk.sv
// port-level checker for the ustar line extractor, bound to the top level
// depends on tsle_pkg
`default_nettype none

module tsle_chk
	import tsle_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       s_axis_tuser,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic [7:0] m_axis_tuser
);

	logic terminal;

	assign terminal = m_axis_tuser[2] || (m_axis_tuser[5:3] != ST_OK);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// a content byte carries no other flag
	a_byte_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			!m_axis_tuser[1] && !m_axis_tuser[2] && m_axis_tuser[5:3] == ST_OK)
		else $error("content byte with extra flags");

	// byte field zero when no content byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
		else $error("nonzero byte without byte_valid");

	// no word directly follows archive end or an error
	a_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && terminal |=> !m_axis_tvalid ##1 !m_axis_tvalid)
		else $error("word after archive end or error");

endmodule

bind tar_stream_line_extractor_core tsle_chk u_tsle_chk (.*);

`default_nettype wire

>>> tb/sv/tb_tar_stream_line_extractor_core.sv
// testbench for tar_stream_line_extractor_core: drives ustar archives one word at a time
// and checks every line result against a cycle-free predictor kept in this module
// depends on tsle_pkg and the core rtl

module tb_tar_stream_line_extractor_core;
	import tsle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAIL_WORDS = 300;
	localparam int FLAW_NONE  = 0;
	localparam int FLAW_MAGIC = 1;
	localparam int FLAW_TERM  = 2;
	localparam int FLAW_DIGIT = 3;
	localparam logic [7:0] USTAR [5] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};
	localparam logic [7:0] FIRST_BODY [10] = '{8'h00, 8'hff, CH_CR, CH_LF, 8'h41,
		CH_CR, CH_LF, 8'h7f, 8'h80, CH_LF};

	typedef struct {
		logic       kind;
		logic [7:0] data;
	} tar_word_t;

	typedef struct {
		logic [7:0] byte_out;
		logic       byte_valid;
		logic       line_end;
		logic       archive_end;
		logic [2:0] status;
	} line_result_t;

	typedef enum int {
		END_ZERO_HDR,
		END_EOS,
		END_MAGIC,
		END_TERM,
		END_DIGIT,
		END_NO_LF,
		END_TRUNC
	} tar_ending_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tuser = KIND_DATA;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [7:0] m_axis_tuser;

	tar_word_t    tar_words_q[$];
	line_result_t line_result_q[$];

	// predictor state
	phase_t      tar_phase;
	logic [8:0]  hdr_pos;
	logic [63:0] body_left;
	logic [8:0]  pad_left;
	logic [63:0] size_acc;
	logic        size_binary;
	logic        hdr_blank;
	logic        hdr_magic_bad;
	logic        hdr_term_bad;
	logic        hdr_digit_bad;

	logic        word_taken = 1'b0;
	logic        src_quiet = 1'b0;
	logic        snk_quiet = 1'b0;
	int          src_gap = 0;
	int          snk_gap = 0;
	int          mismatch_count = 0;
	int          words_taken = 0;
	int          results_seen = 0;
	int          entry_count = 0;
	tar_ending_t ending;

	tar_stream_line_extractor_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_tar_stream_line_extractor_core: FAIL");
		$finish;
	end

	// ---------------- predictor ----------------

	task automatic push_result(input logic [7:0] b, input logic bv, input logic le,
			input logic ae, input logic [2:0] st);
		line_result_t r;
		r.byte_out    = b;
		r.byte_valid  = bv;
		r.line_end    = le;
		r.archive_end = ae;
		r.status      = st;
		line_result_q = {line_result_q, r};
	endtask

	task automatic restart_header();
		hdr_pos       = '0;
		size_acc      = '0;
		size_binary   = 1'b0;
		hdr_blank     = 1'b1;
		hdr_magic_bad = 1'b0;
		hdr_term_bad  = 1'b0;
		hdr_digit_bad = 1'b0;
	endtask

	task automatic stick_with(input logic [2:0] st);
		tar_phase = PH_ERROR;
		push_result(8'h00, 1'b0, 1'b0, 1'b0, st);
	endtask

	task automatic track_tar_word(input logic kind, input logic [7:0] b);
		if (tar_phase == PH_DONE || tar_phase == PH_ERROR)
			return;
		if (kind == KIND_EOS) begin
			if (tar_phase == PH_HEADER && hdr_pos == '0) begin
				tar_phase = PH_DONE;
				push_result(8'h00, 1'b0, 1'b0, 1'b1, ST_OK);
			end else begin
				stick_with(ST_TRUNC);
			end
			return;
		end
		case (tar_phase)
			PH_HEADER: begin
				if (b != 8'h00)
					hdr_blank = 1'b0;
				if (hdr_pos >= POS_MAGIC_FIRST && hdr_pos <= POS_MAGIC_LAST
						&& b != USTAR[hdr_pos - POS_MAGIC_FIRST])
					hdr_magic_bad = 1'b1;
				if (hdr_pos == POS_SIZE_FIRST)
					size_binary = b[7];
				if (hdr_pos >= POS_SIZE_FIRST && hdr_pos <= POS_SIZE_LAST) begin
					if (size_binary) begin
						if (hdr_pos >= POS_SIZE_BIN0)
							size_acc = {size_acc[55:0], b};
					end else if (hdr_pos <= POS_SIZE_DIGEND) begin
						if (b >= CH_ZERO && b <= CH_SEVEN)
							size_acc = (size_acc << 3) + 64'(b - CH_ZERO);
						else
							hdr_digit_bad = 1'b1;
					end else if (b != CH_SPACE && b != CH_NUL) begin
						hdr_term_bad = 1'b1;
					end
				end
				if (hdr_pos != POS_HDR_LAST) begin
					hdr_pos = hdr_pos + 1'b1;
				end else if (hdr_blank) begin
					tar_phase = PH_DONE;
					restart_header();
					push_result(8'h00, 1'b0, 1'b0, 1'b1, ST_OK);
				end else if (hdr_magic_bad) begin
					stick_with(ST_BAD_MAGIC);
				end else if (!size_binary && hdr_term_bad) begin
					stick_with(ST_BAD_TERM);
				end else if (!size_binary && hdr_digit_bad) begin
					stick_with(ST_BAD_DIGIT);
				end else begin
					body_left = size_acc;
					pad_left  = -size_acc[8:0];
					restart_header();
					if (body_left != '0)
						tar_phase = PH_CONTENT;
					else if (pad_left != '0)
						tar_phase = PH_PAD;
					else
						tar_phase = PH_HEADER;
				end
			end
			PH_CONTENT: begin
				body_left = body_left - 1'b1;
				if (body_left == '0) begin
					if (b != CH_LF) begin
						stick_with(ST_NO_LF);
					end else begin
						tar_phase = (pad_left != '0) ? PH_PAD : PH_HEADER;
						push_result(8'h00, 1'b0, 1'b1, 1'b0, ST_OK);
					end
				end else if (b == CH_LF) begin
					push_result(8'h00, 1'b0, 1'b1, 1'b0, ST_OK);
				end else if (b != CH_CR) begin
					push_result(b, 1'b1, 1'b0, 1'b0, ST_OK);
				end
			end
			PH_PAD: begin
				pad_left = pad_left - 1'b1;
				if (pad_left == '0)
					tar_phase = PH_HEADER;
			end
			default: ;
		endcase
	endtask

	// ---------------- stimulus building ----------------

	task automatic put_word(input logic kind, input logic [7:0] b);
		tar_word_t w;
		w.kind = kind;
		w.data = b;
		tar_words_q = {tar_words_q, w};
	endtask

	function automatic logic [7:0] non_octal();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 127)); while (b >= CH_ZERO && b <= CH_SEVEN);
		return b;
	endfunction

	task automatic add_header(input logic [63:0] sz, input bit binary, input int flaw);
		logic [7:0] hdr [BLOCK_BYTES];
		int i;
		for (i = 0; i < BLOCK_BYTES; i++)
			hdr[i] = 8'($urandom_range(0, 255));
		for (i = 0; i < 5; i++)
			hdr[POS_MAGIC_FIRST + i] = USTAR[i];
		if (binary) begin
			hdr[POS_SIZE_FIRST] = 8'h80 | 8'($urandom_range(0, 127));
			for (i = 0; i < 8; i++)
				hdr[POS_SIZE_LAST - i] = sz[8*i +: 8];
		end else begin
			for (i = 0; i < 11; i++)
				hdr[POS_SIZE_DIGEND - i] = CH_ZERO + 8'((sz >> (3*i)) & 64'd7);
			hdr[POS_SIZE_LAST] = $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
		end
		if (flaw == FLAW_MAGIC)
			hdr[POS_MAGIC_FIRST + $urandom_range(0, 4)] ^= 8'($urandom_range(1, 255));
		if (flaw == FLAW_TERM || (flaw == FLAW_MAGIC && $urandom_range(0, 1))) begin
			do hdr[POS_SIZE_LAST] = 8'($urandom_range(0, 255));
			while (hdr[POS_SIZE_LAST] == CH_SPACE || hdr[POS_SIZE_LAST] == CH_NUL);
		end
		if (flaw == FLAW_DIGIT || (flaw != FLAW_NONE && !binary && $urandom_range(0, 1)))
			hdr[POS_SIZE_FIRST + $urandom_range(0, 10)] = non_octal();
		for (i = 0; i < BLOCK_BYTES; i++)
			put_word(KIND_DATA, hdr[i]);
		entry_count++;
	endtask

	task automatic add_pad(input int sz);
		repeat ((BLOCK_BYTES - sz % BLOCK_BYTES) % BLOCK_BYTES)
			put_word(KIND_DATA, 8'($urandom_range(0, 255)));
	endtask

	task automatic add_entry(input int sz, input bit binary, input bit lf_end);
		logic [7:0] b;
		int n;
		add_header(64'(sz), binary, FLAW_NONE);
		for (n = 1; n <= sz; n++) begin
			if (n == sz && lf_end) begin
				b = CH_LF;
			end else if (n == sz) begin
				do b = $urandom_range(0, 2) == 0 ? CH_CR : 8'($urandom_range(0, 255));
				while (b == CH_LF);
			end else begin
				case ($urandom_range(0, 7))
					0: b = CH_LF;
					1: b = CH_CR;
					default: b = 8'($urandom_range(0, 255));
				endcase
			end
			put_word(KIND_DATA, b);
		end
		add_pad(sz);
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return BLOCK_BYTES;
			2: return $urandom_range(480, 700);
			default: return $urandom_range(1, 160);
		endcase
	endfunction

	// ---------------- driver and monitor ----------------

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || word_taken)) begin
			word_taken = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (tar_words_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (!src_quiet && tar_words_q.size() > TAIL_WORDS
					&& $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 8);
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= tar_words_q[0].data;
				s_axis_tuser  <= tar_words_q[0].kind;
				if ($urandom_range(0, 199) == 0)
					src_quiet = !src_quiet;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0) begin
				snk_gap--;
				m_axis_tready <= 1'b0;
			end else if (!snk_quiet && tar_words_q.size() > TAIL_WORDS
					&& $urandom_range(0, 5) == 0) begin
				snk_gap = $urandom_range(0, 8);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 199) == 0)
					snk_quiet = !snk_quiet;
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : monitor
		line_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (line_result_q.size() == 0) begin
					$error("unexpected result: tdata 0x%0h tuser 0x%0h", m_axis_tdata,
						m_axis_tuser);
					mismatch_count++;
				end else begin
					want = line_result_q.pop_front();
					check_field("byte_out", want.byte_out, m_axis_tdata);
					check_field("byte_valid", 8'(want.byte_valid), 8'(m_axis_tuser[0]));
					check_field("line_end", 8'(want.line_end), 8'(m_axis_tuser[1]));
					check_field("archive_end", 8'(want.archive_end), 8'(m_axis_tuser[2]));
					check_field("status", 8'(want.status), 8'(m_axis_tuser[5:3]));
					check_field("tuser pad", 8'h00, 8'(m_axis_tuser[7:6]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				track_tar_word(s_axis_tuser, s_axis_tdata);
				void'(tar_words_q.pop_front());
				word_taken = 1'b1;
				words_taken++;
			end
		end
	end

	// ---------------- run ----------------

	initial begin
		int i;
		int sz;
		int mark;
		tar_phase     = PH_HEADER;
		body_left     = '0;
		pad_left      = '0;
		restart_header();

		// directed: byte extremes, cr, lf, crlf in one entry, then empty and lf-only entries
		add_header(64'd10, 1'b0, FLAW_NONE);
		for (i = 0; i < 10; i++)
			put_word(KIND_DATA, FIRST_BODY[i]);
		add_pad(10);
		add_entry(0, 1'b1, 1'b1);
		add_entry(1, 1'b0, 1'b1);

		repeat ($urandom_range(3, 5))
			add_entry(pick_size(), $urandom_range(0, 2) == 0, 1'b1);

		ending = tar_ending_t'($urandom_range(0, 6));
		case (ending)
			END_ZERO_HDR: repeat (BLOCK_BYTES) put_word(KIND_DATA, 8'h00);
			END_EOS:      put_word(KIND_EOS, 8'($urandom_range(0, 255)));
			END_MAGIC:    add_header(64'($urandom_range(0, 99)), 1'($urandom_range(0, 1)),
				FLAW_MAGIC);
			END_TERM:     add_header(64'($urandom_range(0, 99)), 1'b0, FLAW_TERM);
			END_DIGIT:    add_header(64'($urandom_range(0, 99)), 1'b0, FLAW_DIGIT);
			END_NO_LF:    add_entry($urandom_range(1, 40), 1'($urandom_range(0, 1)), 1'b0);
			END_TRUNC: begin
				mark = tar_words_q.size();
				sz = $urandom_range(1, 200);
				add_entry(sz, 1'($urandom_range(0, 1)), 1'b1);
				repeat ($urandom_range(1, tar_words_q.size() - mark - 1))
					void'(tar_words_q.pop_back());
				put_word(KIND_EOS, 8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		// everything past the ending is ignored by the block
		repeat (16)
			put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (tar_words_q.size() != 0 || line_result_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d archive words over %0d entries in, %0d line results checked",
			words_taken, entry_count, results_seen);
		$display("archive ending exercised: %s", ending.name());
		if (mismatch_count == 0) begin
			$display("tb_tar_stream_line_extractor_core: PASS");
		end else begin
			$display("tb_tar_stream_line_extractor_core: FAIL");
		end
		$finish;
	end

endmodule
